>>> design/kmq_pkg.sv
package kmq_pkg;

  localparam int MAX_OWNERS  = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_WIDTH    = 16;

  localparam int FIELD_W = 16;
  localparam int KEY_W   = (ID_WIDTH < FIELD_W) ? ID_WIDTH : FIELD_W;
  localparam int SLOT_W  = (MAX_OWNERS > 1) ? $clog2(MAX_OWNERS) : 1;
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = MAX_OWNERS * QUEUE_DEPTH;
  localparam int ADDR_W  = $clog2(MEM_DEPTH);

  typedef enum logic [2:0] {
    ACT_REGISTER = 3'd0,
    ACT_REMOVE   = 3'd1,
    ACT_ENQUEUE  = 3'd2,
    ACT_PEEK     = 3'd3,
    ACT_POP      = 3'd4,
    ACT_QUERY    = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_UNKNOWN    = 3'd1,
    STAT_EMPTY      = 3'd2,
    STAT_TABLE_FULL = 3'd3,
    STAT_QUEUE_FULL = 3'd4
  } status_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_READ
  } fsm_t;

endpackage

>>> design/kmq_ifs.sv
interface kmq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [15:0] owner_id;
  logic [15:0] item_id;

  modport source (output valid, action, owner_id, item_id, input ready);
  modport sink   (input valid, action, owner_id, item_id, output ready);
endinterface

interface kmq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] head_item;
  logic        has_waiting;

  modport source (output valid, status, head_item, has_waiting, input ready);
  modport sink   (input valid, status, head_item, has_waiting, output ready);
endinterface

>>> design/keyed_multi_queue_table_core.sv
// Table of up to MAX_OWNERS owner ids, each with a circular FIFO of up to QUEUE_DEPTH item ids
// held in one shared synchronous RAM (slot times depth plus position). Every request gives
// exactly one result transaction. Owner lookup is a parallel compare over the slot registers, so
// register, remove, enqueue, pop, query and failed peeks write the result from the request;
// a successful peek passes the READ state: the head item comes out of a registered RAM port.
// A new request is taken while the last result still waits, as long as its register frees up.
module keyed_multi_queue_table_core (
  input  logic              clk,
  input  logic              rst_n,
  kmq_in_if.sink            in_ch,
  kmq_out_if.source         out_ch
);

  logic [kmq_pkg::KEY_W-1:0] mem [kmq_pkg::MEM_DEPTH];
  logic [kmq_pkg::KEY_W-1:0] rd_data_r;

  logic                      slot_valid_r [kmq_pkg::MAX_OWNERS];
  logic                      slot_valid_nxt [kmq_pkg::MAX_OWNERS];
  logic [kmq_pkg::KEY_W-1:0] slot_owner_r [kmq_pkg::MAX_OWNERS];
  logic [kmq_pkg::PTR_W-1:0] head_ptr_r [kmq_pkg::MAX_OWNERS];
  logic [kmq_pkg::PTR_W-1:0] head_ptr_nxt [kmq_pkg::MAX_OWNERS];
  logic [kmq_pkg::CNT_W-1:0] count_r [kmq_pkg::MAX_OWNERS];
  logic [kmq_pkg::CNT_W-1:0] count_nxt [kmq_pkg::MAX_OWNERS];

  kmq_pkg::fsm_t state_r, state_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic [15:0] out_head_r, out_head_nxt;
  logic        out_wait_r, out_wait_nxt;

  logic                      fire;
  logic [kmq_pkg::KEY_W-1:0] key;
  logic [kmq_pkg::KEY_W-1:0] item;
  logic                      found;
  logic                      has_free;
  logic [kmq_pkg::SLOT_W-1:0] hit_idx;
  logic [kmq_pkg::SLOT_W-1:0] free_idx;
  logic [kmq_pkg::CNT_W-1:0] cnt_s;
  logic [kmq_pkg::PTR_W-1:0] hp_s;
  logic [kmq_pkg::CNT_W:0]   tail_sum;
  logic [kmq_pkg::PTR_W-1:0] tail_pos;
  logic [kmq_pkg::PTR_W:0]   hp_inc;
  logic [kmq_pkg::PTR_W-1:0] hp_next;
  logic                      claim;
  logic                      wr_en;
  logic                      rd_en;
  logic [kmq_pkg::ADDR_W-1:0] mem_addr;
  logic [kmq_pkg::PTR_W-1:0] mem_pos;

  assign key  = in_ch.owner_id[kmq_pkg::KEY_W-1:0];
  assign item = in_ch.item_id[kmq_pkg::KEY_W-1:0];

  assign in_ch.ready = (state_r == kmq_pkg::FSM_IDLE) && (!out_valid_r || out_ch.ready);
  assign fire        = in_ch.valid && in_ch.ready;

  // owner lookup, lowest slot wins
  always_comb begin
    found    = 1'b0;
    has_free = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int s = kmq_pkg::MAX_OWNERS - 1; s >= 0; s--) begin
      if (slot_valid_r[s] && slot_owner_r[s] == key) begin
        found   = 1'b1;
        hit_idx = kmq_pkg::SLOT_W'(s);
      end
      if (!slot_valid_r[s]) begin
        has_free = 1'b1;
        free_idx = kmq_pkg::SLOT_W'(s);
      end
    end
  end

  assign cnt_s    = count_r[hit_idx];
  assign hp_s     = head_ptr_r[hit_idx];
  assign tail_sum = (kmq_pkg::CNT_W+1)'(hp_s) + (kmq_pkg::CNT_W+1)'(cnt_s);
  assign tail_pos = (tail_sum >= (kmq_pkg::CNT_W+1)'(kmq_pkg::QUEUE_DEPTH))
                    ? kmq_pkg::PTR_W'(tail_sum - (kmq_pkg::CNT_W+1)'(kmq_pkg::QUEUE_DEPTH))
                    : kmq_pkg::PTR_W'(tail_sum);
  assign hp_inc   = (kmq_pkg::PTR_W+1)'(hp_s) + (kmq_pkg::PTR_W+1)'(1);
  assign hp_next  = (hp_inc == (kmq_pkg::PTR_W+1)'(kmq_pkg::QUEUE_DEPTH))
                    ? '0 : kmq_pkg::PTR_W'(hp_inc);

  assign mem_pos  = (in_ch.action == kmq_pkg::ACT_ENQUEUE) ? tail_pos : hp_s;
  assign mem_addr = kmq_pkg::ADDR_W'(hit_idx) * kmq_pkg::ADDR_W'(kmq_pkg::QUEUE_DEPTH)
                    + kmq_pkg::ADDR_W'(mem_pos);

  always_comb begin
    slot_valid_nxt = slot_valid_r;
    head_ptr_nxt   = head_ptr_r;
    count_nxt      = count_r;
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_head_nxt   = out_head_r;
    out_wait_nxt   = out_wait_r;
    claim          = 1'b0;
    wr_en          = 1'b0;
    rd_en          = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      kmq_pkg::FSM_IDLE: begin
        if (fire) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = kmq_pkg::STAT_OK;
          out_head_nxt   = '0;
          out_wait_nxt   = found && (cnt_s != '0);
          case (in_ch.action)
            kmq_pkg::ACT_REGISTER: begin
              if (!found) begin
                if (!has_free) begin
                  out_status_nxt = kmq_pkg::STAT_TABLE_FULL;
                end else begin
                  claim                    = 1'b1;
                  slot_valid_nxt[free_idx] = 1'b1;
                  head_ptr_nxt[free_idx]   = '0;
                  count_nxt[free_idx]      = '0;
                end
              end
            end
            kmq_pkg::ACT_REMOVE: begin
              if (!found) begin
                out_status_nxt = kmq_pkg::STAT_UNKNOWN;
              end else begin
                slot_valid_nxt[hit_idx] = 1'b0;
                head_ptr_nxt[hit_idx]   = '0;
                count_nxt[hit_idx]      = '0;
                out_wait_nxt            = 1'b0;
              end
            end
            kmq_pkg::ACT_ENQUEUE: begin
              if (!found) begin
                out_status_nxt = kmq_pkg::STAT_UNKNOWN;
              end else if (cnt_s >= kmq_pkg::CNT_W'(kmq_pkg::QUEUE_DEPTH)) begin
                out_status_nxt = kmq_pkg::STAT_QUEUE_FULL;
              end else begin
                wr_en              = 1'b1;
                count_nxt[hit_idx] = cnt_s + kmq_pkg::CNT_W'(1);
                out_wait_nxt       = 1'b1;
              end
            end
            kmq_pkg::ACT_PEEK: begin
              if (!found) begin
                out_status_nxt = kmq_pkg::STAT_UNKNOWN;
              end else if (cnt_s == '0) begin
                out_status_nxt = kmq_pkg::STAT_EMPTY;
              end else begin
                rd_en         = 1'b1;
                out_valid_nxt = 1'b0;
                state_nxt     = kmq_pkg::FSM_READ;
              end
            end
            kmq_pkg::ACT_POP: begin
              if (!found) begin
                out_status_nxt = kmq_pkg::STAT_UNKNOWN;
              end else if (cnt_s == '0) begin
                out_status_nxt = kmq_pkg::STAT_EMPTY;
              end else begin
                head_ptr_nxt[hit_idx] = hp_next;
                count_nxt[hit_idx]    = cnt_s - kmq_pkg::CNT_W'(1);
                out_wait_nxt          = (cnt_s != kmq_pkg::CNT_W'(1));
              end
            end
            kmq_pkg::ACT_QUERY: begin
              if (!found) begin
                out_status_nxt = kmq_pkg::STAT_UNKNOWN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      kmq_pkg::FSM_READ: begin
        // result register is free here, peek only issued when it could drain
        out_valid_nxt  = 1'b1;
        out_status_nxt = kmq_pkg::STAT_OK;
        out_head_nxt   = 16'(rd_data_r);
        out_wait_nxt   = 1'b1;
        state_nxt      = kmq_pkg::FSM_IDLE;
      end
      default: begin
        state_nxt = kmq_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kmq_pkg::FSM_IDLE;
      out_valid_r <= 1'b0;
      for (int s = 0; s < kmq_pkg::MAX_OWNERS; s++) begin
        slot_valid_r[s] <= 1'b0;
        head_ptr_r[s]   <= '0;
        count_r[s]      <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      slot_valid_r <= slot_valid_nxt;
      head_ptr_r   <= head_ptr_nxt;
      count_r      <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_head_r   <= out_head_nxt;
    out_wait_r   <= out_wait_nxt;
    if (claim) begin
      slot_owner_r[free_idx] <= key;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[mem_addr] <= item;
    end
    if (rd_en) begin
      rd_data_r <= mem[mem_addr];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.head_item   = out_head_r;
  assign out_ch.has_waiting = out_wait_r;

endmodule
